// File: rtl/core/assert_macros.svh
// Assertion macros shared by the histogram core RTL.
// Each macro expects clk and arst_n to exist in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/core/ihist_pkg.sv
// Types and constants for the intensity histogram core.
// No dependencies; imported by every module of the core.
package ihist_pkg;

	localparam int BIN_NUM          = 256;
	localparam int BIN_W            = $clog2(BIN_NUM);
	localparam int SAMPLE_W         = 8;
	localparam int SAMPLE_NUM       = 4;
	localparam int SUM_W            = 10;
	localparam int CHAN_W           = 3;
	localparam int RES_COUNT_W      = 32;
	localparam int COUNT_WIDTH_DEF  = 32;
	localparam int MAX_CHANNELS_DEF = 4;
	// floor(x/3) == (x*683)>>11 for every x below 1024
	localparam int RECIP3           = 683;
	localparam int RECIP3_SHIFT     = 11;
	localparam int PROD_W           = SUM_W + RECIP3_SHIFT;
	localparam logic [CHAN_W-1:0] CHAN_RESET = CHAN_W'(1);

	typedef enum logic {
		MODE_ADD  = 1'b0,
		MODE_READ = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t                mode;
		logic [SAMPLE_W-1:0]  sample_0;
		logic [SAMPLE_W-1:0]  sample_1;
		logic [SAMPLE_W-1:0]  sample_2;
		logic [SAMPLE_W-1:0]  sample_3;
		logic [BIN_W-1:0]     read_bin;
	} ihist_pix_t;

	typedef struct packed {
		logic [BIN_W-1:0]       bin_index;
		logic [RES_COUNT_W-1:0] bin_count;
	} ihist_res_t;

	// Operation handed from the bin stage to the store
	typedef struct packed {
		logic             vld;
		mode_t            mode;
		logic [BIN_W-1:0] bin;
	} ihist_op_t;

	// Read-back word leaving the store
	typedef struct packed {
		logic       fire;
		ihist_res_t res;
	} ihist_wb_t;

endpackage

// File: rtl/core/intensity_histogram_core.sv
// Intensity histogram core, top level.
// Depends on ihist_pkg, ihist_bin_calc, ihist_store.
//
// Usage:
//   pix (valid/ready) carries one word per pixel or bin read. mode ADD folds
//   the average of the first channel_count samples into its bin; mode READ
//   returns the addressed bin's count on res and clears that bin.
//   cfg_we/cfg_wdata write channel_count; write it only while the core is idle.
// Path: a READ word is registered in op_s1, op_s2 and then the res register.
// Throughput: 1 word/cycle unless stalled, set by the single read-modify-write
//   port of the bin memory; back-to-back hits on one bin resolve by forwarding.
// Stall: while res holds an untaken word the whole pipeline freezes and
//   pix_ready drops; it resumes in the cycle res_ready returns.
// Reset: arst_n clears all bins (per-bin valid bits, no clearing pass),
//   empties the pipeline and sets channel_count to 1. The core takes words
//   as soon as reset is released.
// Counters saturate at all ones; res.bin_count carries the low 32 bits.
`include "assert_macros.svh"

module intensity_histogram_core #(
	parameter int COUNT_WIDTH  = ihist_pkg::COUNT_WIDTH_DEF,
	parameter int MAX_CHANNELS = ihist_pkg::MAX_CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	output logic                          pix_ready,
	input  ihist_pkg::ihist_pix_t         pix,
	output logic                          res_valid,
	input  logic                          res_ready,
	output ihist_pkg::ihist_res_t         res,
	input  logic                          cfg_we,
	input  logic [ihist_pkg::CHAN_W-1:0]  cfg_wdata
);
	import ihist_pkg::*;

	logic              chan_q;
	logic [CHAN_W-1:0] chan_cnt_q;
	logic              adv;
	logic              acc;
	logic              res_valid_q;
	ihist_res_t        res_q;
	ihist_op_t         op_s1;
	ihist_wb_t         wb;

	// Channel count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q <= CHAN_RESET;
			chan_q     <= 1'b0;
		end else if (cfg_we) begin
			chan_cnt_q <= cfg_wdata;
			chan_q     <= 1'b1;
		end
	end

	// Freeze everything while the output word waits
	assign adv       = !(res_valid_q && !res_ready);
	assign acc       = pix_valid && adv;
	assign pix_ready = adv;

	ihist_bin_calc #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_bin_calc (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.acc   (acc),
		.pix   (pix),
		.chan  (chan_cnt_q),
		.op_s1 (op_s1)
	);

	ihist_store #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.op_s1 (op_s1),
		.wb    (wb)
	);

	// Output register: load on a read commit, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= wb.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && wb.fire) begin
			res_q <= wb.res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`ASSERT_NEXT(a_res_only_from_read, adv && !wb.fire, !res_valid)
	`ASSERT_NEXT(a_cfg_loaded, cfg_we, chan_q && (chan_cnt_q == $past(cfg_wdata)))

endmodule

// File: rtl/core/ihist_bin_calc.sv
// Bin stage: 8-bit bin index, the active-sample average or READ's read_bin.
// Depends on ihist_pkg.
`include "assert_macros.svh"

module ihist_bin_calc #(
	parameter int MAX_CHANNELS = ihist_pkg::MAX_CHANNELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic                           acc,
	input  ihist_pkg::ihist_pix_t          pix,
	input  logic [ihist_pkg::CHAN_W-1:0]   chan,
	output ihist_pkg::ihist_op_t           op_s1
);
	import ihist_pkg::*;

	logic [CHAN_W-1:0]   n_eff;
	logic [SAMPLE_W-1:0] smp [SAMPLE_NUM];
	logic [SUM_W-1:0]    sum;
	logic [PROD_W-1:0]   prod;
	logic [BIN_W-1:0]    quo;
	logic [BIN_W-1:0]    bin;

	assign smp[0] = pix.sample_0;
	assign smp[1] = pix.sample_1;
	assign smp[2] = pix.sample_2;
	assign smp[3] = pix.sample_3;

	// Clamp the channel count into 1..MAX_CHANNELS
	always_comb begin
		n_eff = chan;
		if (chan == '0) begin
			n_eff = CHAN_W'(1);
		end
		if (n_eff > CHAN_W'(MAX_CHANNELS)) begin
			n_eff = CHAN_W'(MAX_CHANNELS);
		end
	end

	// Sum the active samples
	always_comb begin
		sum = '0;
		for (int c = 0; c < SAMPLE_NUM; c++) begin
			if (c < int'(n_eff)) begin
				sum = sum + SUM_W'(smp[c]);
			end
		end
	end

	// Divide by the count: shifts for 1, 2, 4, reciprocal multiply for 3
	assign prod = PROD_W'(sum) * PROD_W'(RECIP3);

	always_comb begin
		case (n_eff)
			CHAN_W'(2): quo = sum[1 +: BIN_W];
			CHAN_W'(3): quo = prod[RECIP3_SHIFT +: BIN_W];
			CHAN_W'(4): quo = sum[2 +: BIN_W];
			default:    quo = sum[BIN_W-1:0];
		endcase
	end

	assign bin = (pix.mode == MODE_READ) ? pix.read_bin : quo;

	// Advance the stage; drop the slot when nothing was taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else if (adv) begin
			op_s1.vld  <= acc;
			op_s1.mode <= pix.mode;
			op_s1.bin  <= bin;
		end
	end

	`ASSERT_NEXT(a_s1_empty_no_acc, adv && !acc, !op_s1.vld)

endmodule

// File: rtl/core/ihist_store.sv
// Bin store: 256-entry counter memory with read-modify-write and forwarding.
// Depends on ihist_pkg.
`include "assert_macros.svh"

module ihist_store #(
	parameter int COUNT_WIDTH = ihist_pkg::COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  ihist_pkg::ihist_op_t  op_s1,
	output ihist_pkg::ihist_wb_t  wb
);
	import ihist_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	logic [COUNT_WIDTH-1:0] mem [BIN_NUM];
	logic [BIN_NUM-1:0]     vld_q;

	ihist_op_t              op_s2;
	logic [COUNT_WIDTH-1:0] rdata_s2;
	logic                   vbit_s2;
	logic                   fwd_s2;
	logic [COUNT_WIDTH-1:0] fwd_data_s2;
	logic [COUNT_WIDTH-1:0] cur;
	logic [COUNT_WIDTH-1:0] new_cnt;
	logic                   wr_en;

	// Pick the live count: forwarded write, stored value, or zero if never written
	always_comb begin
		if (fwd_s2) begin
			cur = fwd_data_s2;
		end else if (vbit_s2) begin
			cur = rdata_s2;
		end else begin
			cur = '0;
		end
	end

	// Clear on read, saturating increment on add
	always_comb begin
		if (op_s2.mode == MODE_READ) begin
			new_cnt = '0;
		end else if (cur == CNT_MAX) begin
			new_cnt = cur;
		end else begin
			new_cnt = cur + COUNT_WIDTH'(1);
		end
	end

	assign wr_en = adv && op_s2.vld;

	// Memory: write back stage 2, read for stage 1
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[op_s2.bin] <= new_cnt;
		end
		if (adv) begin
			rdata_s2 <= mem[op_s1.bin];
		end
	end

	// Valid bits: an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[op_s2.bin] <= 1'b1;
		end
	end

	// Advance stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s2 <= '0;
		end else if (adv) begin
			op_s2 <= op_s1;
		end
	end

	// Catch a write to the same bin landing at the read edge
	always_ff @(posedge clk) begin
		if (adv) begin
			vbit_s2     <= vld_q[op_s1.bin];
			fwd_s2      <= op_s2.vld && (op_s2.bin == op_s1.bin);
			fwd_data_s2 <= new_cnt;
		end
	end

	// Hand the read-back word to the output register
	assign wb.fire          = wr_en && (op_s2.mode == MODE_READ);
	assign wb.res.bin_index = op_s2.bin;
	assign wb.res.bin_count = RES_COUNT_W'(cur);

	`ASSERT_NEXT(a_wr_sets_valid, wr_en, vld_q[$past(op_s2.bin)])
	`ASSERT_NEXT(a_stall_holds_s2, !adv, $stable(op_s2.vld) && $stable(op_s2.bin))

endmodule
